### hdl/locm_pkg.sv
// Shared constants and register codes for the chassis drive mixer.
`timescale 1ns / 1ps
package locm_pkg;

  localparam int DataWidthDef = 16;
  localparam int GainW        = 16;
  localparam int CmdW         = 16;
  localparam int LimitW       = 15;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int FracShift    = 24;
  localparam int ClampExp     = 46;
  // wide enough to carry a clamped mix of magnitude 2**ClampExp
  localparam int ClampW       = ClampExp + 2;
  localparam int Stages       = 6;

  localparam logic signed [GainW-1:0] PosGainReset = 16'sd384;
  localparam logic signed [GainW-1:0] VelGainReset = 16'sd26;
  localparam logic signed [GainW-1:0] ScaleReset   = 16'sd256;
  localparam logic [LimitW-1:0]       LimitReset   = 15'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainXPos    = 3'd0,
    CfgGainXVel    = 3'd1,
    CfgGainYPos    = 3'd2,
    CfgGainYVel    = 3'd3,
    CfgGainTurnPos = 3'd4,
    CfgGainTurnVel = 3'd5,
    CfgWheelScale  = 3'd6,
    CfgOutputLimit = 3'd7
  } cfg_reg_t;

endpackage

### hdl/locm_if.sv
// Valid/ready channel interfaces for sample sets and wheel commands.
`timescale 1ns / 1ps
interface locm_in_if #(
  parameter int DATA_WIDTH = locm_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic signed [DATA_WIDTH-1:0] x_rate;
  logic signed [DATA_WIDTH-1:0] x_target;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic signed [DATA_WIDTH-1:0] y_rate;
  logic signed [DATA_WIDTH-1:0] y_target;
  logic signed [DATA_WIDTH-1:0] turn_value;
  logic signed [DATA_WIDTH-1:0] turn_rate;
  logic signed [DATA_WIDTH-1:0] turn_target;

  modport source (
    output valid, x_value, x_rate, x_target, y_value, y_rate, y_target,
           turn_value, turn_rate, turn_target,
    input  ready
  );
  modport sink (
    input  valid, x_value, x_rate, x_target, y_value, y_rate, y_target,
           turn_value, turn_rate, turn_target,
    output ready
  );
endinterface

interface locm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [locm_pkg::CmdW-1:0]     front_left_cmd;
  logic signed [locm_pkg::CmdW-1:0]     front_right_cmd;
  logic signed [locm_pkg::CmdW-1:0]     back_left_cmd;
  logic signed [locm_pkg::CmdW-1:0]     back_right_cmd;

  modport source (
    output valid, front_left_cmd, front_right_cmd, back_left_cmd, back_right_cmd,
    input  ready
  );
  modport sink (
    input  valid, front_left_cmd, front_right_cmd, back_left_cmd, back_right_cmd,
    output ready
  );
endinterface

### hdl/locm_axis.sv
// One axis of state feedback: error, gain products and effort, three stages.
`timescale 1ns / 1ps
module locm_axis #(
  parameter int DATA_WIDTH = locm_pkg::DataWidthDef
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [locm_pkg::GainW-1:0]     kpos,
  input  logic signed [locm_pkg::GainW-1:0]     kvel,
  input  logic signed [DATA_WIDTH-1:0]          value,
  input  logic signed [DATA_WIDTH-1:0]          rate,
  input  logic signed [DATA_WIDTH-1:0]          target,
  output logic signed [DATA_WIDTH+17:0]         effort
);

  localparam int ErrW  = DATA_WIDTH + 1;
  localparam int PosW  = ErrW + locm_pkg::GainW;
  localparam int VelW  = DATA_WIDTH + locm_pkg::GainW;
  localparam int EffW  = DATA_WIDTH + 18;

  logic signed [ErrW-1:0]       err;
  logic signed [DATA_WIDTH-1:0] drate;
  logic signed [PosW-1:0]       pos_prod;
  logic signed [VelW-1:0]       vel_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      err      <= ErrW'(value) - ErrW'(target);
      drate    <= rate;
      pos_prod <= PosW'(kpos) * PosW'(err);
      vel_prod <= VelW'(kvel) * VelW'(drate);
      effort   <= -(EffW'(pos_prod) + EffW'(vel_prod));
    end
  end

endmodule

### hdl/locm_wheel.sv
// One wheel: clamp mixed effort, scale, floor to integer and saturate.
`timescale 1ns / 1ps
module locm_wheel #(
  parameter int DATA_WIDTH = locm_pkg::DataWidthDef
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [DATA_WIDTH+18:0]         mix,
  input  logic signed [locm_pkg::GainW-1:0]     scale,
  input  logic [locm_pkg::LimitW-1:0]           limit,
  output logic signed [locm_pkg::CmdW-1:0]      cmd
);

  localparam int MixW  = DATA_WIDTH + 19;
  localparam int CW    = (MixW >= locm_pkg::ClampW) ? locm_pkg::ClampW : MixW;
  localparam int ProdW = CW + locm_pkg::GainW;
  localparam int ShW   = ProdW - locm_pkg::FracShift;

  logic signed [CW-1:0]    mix_c;
  logic signed [CW-1:0]    mix_q;
  logic signed [ProdW-1:0] prod;
  logic signed [ShW-1:0]   whole;
  logic signed [ShW-1:0]   lim_s;
  logic signed [locm_pkg::CmdW-1:0] cmd_next;

  generate
    if (MixW >= locm_pkg::ClampW) begin : g_clamp
      localparam logic signed [MixW-1:0] Hi = MixW'(1) << locm_pkg::ClampExp;
      localparam logic signed [MixW-1:0] Lo = -Hi;
      always_comb begin
        if (mix > Hi) begin
          mix_c = CW'(Hi);
        end else if (mix < Lo) begin
          mix_c = CW'(Lo);
        end else begin
          mix_c = CW'(mix);
        end
      end
    end else begin : g_pass
      // too narrow to ever reach the clamp
      assign mix_c = mix;
    end
  endgenerate

  // arithmetic shift of the product rounds toward minus infinity
  assign whole = prod[ProdW-1:locm_pkg::FracShift];
  assign lim_s = ShW'($signed({1'b0, limit}));

  always_comb begin
    if (whole > lim_s) begin
      cmd_next = locm_pkg::CmdW'(lim_s);
    end else if (whole < -lim_s) begin
      cmd_next = locm_pkg::CmdW'(-lim_s);
    end else begin
      cmd_next = whole[locm_pkg::CmdW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mix_q <= mix_c;
      prod  <= ProdW'(mix_q) * ProdW'(scale);
      cmd   <= cmd_next;
    end
  end

endmodule

### hdl/lqr_omni_chassis_drive_mixer.sv
// Top level: gain registers, three axis controllers and four wheel channels.
`timescale 1ns / 1ps
// Six-stage pipeline: error, gain products, axis effort, wheel mix and clamp,
// scale product, floor shift and saturation. One sample set is taken every
// cycle unless stalled, and its four wheel commands leave together; the whole
// pipeline holds while a finished set waits on the output. Gains, scale and
// limit come from the configuration port and must only change while no set
// is in flight. Commands are the scaled efforts floored to integers and
// clipped to +/- output_limit.
module lqr_omni_chassis_drive_mixer #(
  parameter int DATA_WIDTH = locm_pkg::DataWidthDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [locm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [locm_pkg::CfgDataW-1:0]     cfg_data,
  locm_in_if.sink                           samples,
  locm_out_if.source                        commands
);

  localparam int EffW = DATA_WIDTH + 18;
  localparam int MixW = DATA_WIDTH + 19;

  logic signed [locm_pkg::GainW-1:0] gain_x_pos, gain_x_vel;
  logic signed [locm_pkg::GainW-1:0] gain_y_pos, gain_y_vel;
  logic signed [locm_pkg::GainW-1:0] gain_turn_pos, gain_turn_vel;
  logic signed [locm_pkg::GainW-1:0] wheel_scale;
  logic [locm_pkg::LimitW-1:0]       output_limit;

  logic [locm_pkg::Stages-1:0] vld;
  logic                        en;
  logic signed [EffW-1:0]      u_x, u_y, u_t;
  logic signed [MixW-1:0]      mix_fl, mix_fr, mix_bl, mix_br;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x_pos    <= locm_pkg::PosGainReset;
      gain_x_vel    <= locm_pkg::VelGainReset;
      gain_y_pos    <= locm_pkg::PosGainReset;
      gain_y_vel    <= locm_pkg::VelGainReset;
      gain_turn_pos <= locm_pkg::PosGainReset;
      gain_turn_vel <= locm_pkg::VelGainReset;
      wheel_scale   <= locm_pkg::ScaleReset;
      output_limit  <= locm_pkg::LimitReset;
    end else if (cfg_write) begin
      case (locm_pkg::cfg_reg_t'(cfg_index))
        locm_pkg::CfgGainXPos:    gain_x_pos    <= cfg_data;
        locm_pkg::CfgGainXVel:    gain_x_vel    <= cfg_data;
        locm_pkg::CfgGainYPos:    gain_y_pos    <= cfg_data;
        locm_pkg::CfgGainYVel:    gain_y_vel    <= cfg_data;
        locm_pkg::CfgGainTurnPos: gain_turn_pos <= cfg_data;
        locm_pkg::CfgGainTurnVel: gain_turn_vel <= cfg_data;
        locm_pkg::CfgWheelScale:  wheel_scale   <= cfg_data;
        locm_pkg::CfgOutputLimit: output_limit  <= cfg_data[locm_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the output holds an untaken set
  assign en            = !vld[locm_pkg::Stages-1] || commands.ready;
  assign samples.ready = en;
  assign commands.valid = vld[locm_pkg::Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[locm_pkg::Stages-2:0], samples.valid};
    end
  end

  locm_axis #(.DATA_WIDTH(DATA_WIDTH)) u_axis_x (
    .clk(clk), .en(en), .kpos(gain_x_pos), .kvel(gain_x_vel),
    .value(samples.x_value), .rate(samples.x_rate), .target(samples.x_target),
    .effort(u_x)
  );
  locm_axis #(.DATA_WIDTH(DATA_WIDTH)) u_axis_y (
    .clk(clk), .en(en), .kpos(gain_y_pos), .kvel(gain_y_vel),
    .value(samples.y_value), .rate(samples.y_rate), .target(samples.y_target),
    .effort(u_y)
  );
  locm_axis #(.DATA_WIDTH(DATA_WIDTH)) u_axis_t (
    .clk(clk), .en(en), .kpos(gain_turn_pos), .kvel(gain_turn_vel),
    .value(samples.turn_value), .rate(samples.turn_rate),
    .target(samples.turn_target), .effort(u_t)
  );

  assign mix_fl =  MixW'(u_y) + MixW'(u_t);
  assign mix_fr = -MixW'(u_x) - MixW'(u_t);
  assign mix_bl = -MixW'(u_x) + MixW'(u_t);
  assign mix_br =  MixW'(u_y) - MixW'(u_t);

  locm_wheel #(.DATA_WIDTH(DATA_WIDTH)) u_wheel_fl (
    .clk(clk), .en(en), .mix(mix_fl), .scale(wheel_scale), .limit(output_limit),
    .cmd(commands.front_left_cmd)
  );
  locm_wheel #(.DATA_WIDTH(DATA_WIDTH)) u_wheel_fr (
    .clk(clk), .en(en), .mix(mix_fr), .scale(wheel_scale), .limit(output_limit),
    .cmd(commands.front_right_cmd)
  );
  locm_wheel #(.DATA_WIDTH(DATA_WIDTH)) u_wheel_bl (
    .clk(clk), .en(en), .mix(mix_bl), .scale(wheel_scale), .limit(output_limit),
    .cmd(commands.back_left_cmd)
  );
  locm_wheel #(.DATA_WIDTH(DATA_WIDTH)) u_wheel_br (
    .clk(clk), .en(en), .mix(mix_br), .scale(wheel_scale), .limit(output_limit),
    .cmd(commands.back_right_cmd)
  );

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    commands.valid |->
      commands.front_left_cmd  <= $signed({2'b00, output_limit}) &&
      commands.front_left_cmd  >= -$signed({2'b00, output_limit}) &&
      commands.front_right_cmd <= $signed({2'b00, output_limit}) &&
      commands.front_right_cmd >= -$signed({2'b00, output_limit}))
    else $error("front wheel command beyond limit");

  a_back_bound: assert property (@(posedge clk) disable iff (rst)
    commands.valid |->
      commands.back_left_cmd  <= $signed({2'b00, output_limit}) &&
      commands.back_left_cmd  >= -$signed({2'b00, output_limit}) &&
      commands.back_right_cmd <= $signed({2'b00, output_limit}) &&
      commands.back_right_cmd >= -$signed({2'b00, output_limit}))
    else $error("back wheel command beyond limit");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> vld[0])
    else $error("transfer in did not reach first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("pipeline valid bits moved during stall");

endmodule

### tb/locm_mixer_checker.sv
// Scoreboard for the chassis drive mixer: predicts wheel commands and checks each output transfer.
`timescale 1ns / 1ps
module locm_mixer_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [locm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [locm_pkg::CfgDataW-1:0] cfg_data,
  locm_in_if                            samples,
  locm_out_if                           commands,
  output int                            failures,
  output int                            outstanding
);

  localparam int DW = locm_pkg::DataWidthDef;
  localparam longint MixClamp = longint'(1) << locm_pkg::ClampExp;

  // element 0 front left, 1 front right, 2 back left, 3 back right
  typedef logic [3:0][locm_pkg::CmdW-1:0] wheel_cmds_t;

  // axis order: x, y, turn
  logic signed [locm_pkg::GainW-1:0] gain_pos [3];
  logic signed [locm_pkg::GainW-1:0] gain_vel [3];
  logic signed [locm_pkg::GainW-1:0] scale;
  logic [locm_pkg::LimitW-1:0]       limit;

  wheel_cmds_t cmds_due [$];
  string wheel_name [4] = '{"front_left", "front_right", "back_left", "back_right"};

  function automatic wheel_cmds_t mix_wheel_commands(input logic signed [DW-1:0] v [3],
                                                     input logic signed [DW-1:0] r [3],
                                                     input logic signed [DW-1:0] t [3]);
    longint effort [3];
    longint mix [4];
    longint lim, m, cmd;
    wheel_cmds_t res;
    for (int a = 0; a < 3; a++)
      effort[a] = -(longint'(gain_pos[a]) * (longint'(v[a]) - longint'(t[a]))
                    + longint'(gain_vel[a]) * longint'(r[a]));
    mix[0] = effort[1] + effort[2];
    mix[1] = -effort[0] - effort[2];
    mix[2] = -effort[0] + effort[2];
    mix[3] = effort[1] - effort[2];
    lim = longint'(limit);
    for (int w = 0; w < 4; w++) begin
      m = mix[w];
      if (m > MixClamp) m = MixClamp;
      if (m < -MixClamp) m = -MixClamp;
      // arithmetic shift floors toward minus infinity
      cmd = (m * longint'(scale)) >>> locm_pkg::FracShift;
      if (cmd > lim) cmd = lim;
      if (cmd < -lim) cmd = -lim;
      res[w] = cmd[locm_pkg::CmdW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    wheel_cmds_t want, got;
    logic signed [DW-1:0] v [3];
    logic signed [DW-1:0] r [3];
    logic signed [DW-1:0] t [3];
    if (rst) begin
      gain_pos = '{locm_pkg::PosGainReset, locm_pkg::PosGainReset, locm_pkg::PosGainReset};
      gain_vel = '{locm_pkg::VelGainReset, locm_pkg::VelGainReset, locm_pkg::VelGainReset};
      scale = locm_pkg::ScaleReset;
      limit = locm_pkg::LimitReset;
      cmds_due.delete();
      failures = 0;
    end else begin
      if (cfg_write) begin
        case (locm_pkg::cfg_reg_t'(cfg_index))
          locm_pkg::CfgGainXPos:    gain_pos[0] = cfg_data;
          locm_pkg::CfgGainXVel:    gain_vel[0] = cfg_data;
          locm_pkg::CfgGainYPos:    gain_pos[1] = cfg_data;
          locm_pkg::CfgGainYVel:    gain_vel[1] = cfg_data;
          locm_pkg::CfgGainTurnPos: gain_pos[2] = cfg_data;
          locm_pkg::CfgGainTurnVel: gain_vel[2] = cfg_data;
          locm_pkg::CfgWheelScale:  scale = cfg_data;
          locm_pkg::CfgOutputLimit: limit = cfg_data[locm_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      if (commands.valid && commands.ready) begin
        got = {commands.back_right_cmd, commands.back_left_cmd,
               commands.front_right_cmd, commands.front_left_cmd};
        if (cmds_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected command transfer fl=%0d fr=%0d bl=%0d br=%0d, %s",
                   $time, commands.front_left_cmd, commands.front_right_cmd,
                   commands.back_left_cmd, commands.back_right_cmd, "expected none");
        end else begin
          want = cmds_due.pop_front();
          for (int w = 0; w < 4; w++) begin
            if (got[w] !== want[w]) begin
              failures++;
              $display("%0t: %s command mismatch: expected %0d, got %0d",
                       $time, wheel_name[w], $signed(want[w]), $signed(got[w]));
            end
          end
        end
      end
      if (samples.valid && samples.ready) begin
        v = '{samples.x_value, samples.y_value, samples.turn_value};
        r = '{samples.x_rate, samples.y_rate, samples.turn_rate};
        t = '{samples.x_target, samples.y_target, samples.turn_target};
        cmds_due.push_back(mix_wheel_commands(v, r, t));
      end
    end
    outstanding <= cmds_due.size();
  end

endmodule

### tb/tb_lqr_omni_chassis_drive_mixer.sv
// Testbench top: clock, reset, register settings, sample stimulus and verdict for the drive mixer.
`timescale 1ns / 1ps
module tb_lqr_omni_chassis_drive_mixer;

  localparam int DW = locm_pkg::DataWidthDef;
  localparam int QuietLimit = 4000;
  localparam int SetsPerSetting = 140;
  localparam int HoldCycles = 80;
  localparam logic signed [DW-1:0] MaxV = 16'sh7fff;
  localparam logic signed [DW-1:0] MinV = 16'sh8000;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [locm_pkg::CfgIdxW-1:0]  cfg_index;
  logic [locm_pkg::CfgDataW-1:0] cfg_data;
  int                            failures;
  int                            outstanding;

  int src_idle = 0;
  int snk_stall = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;
  int sets_sent = 0;
  int settings_used = 0;

  int src_pct [4] = '{0, 49, 0, 23};
  int snk_pct [4] = '{0, 0, 49, 23};

  locm_in_if  samples ();
  locm_out_if commands ();

  lqr_omni_chassis_drive_mixer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .commands  (commands)
  );

  locm_mixer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples     (samples),
    .commands    (commands),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // field order: x value/rate/target, y value/rate/target, turn value/rate/target
  task automatic send_axes(input logic signed [DW-1:0] f [9]);
    while ($urandom_range(99) < src_idle) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid       <= 1'b1;
    samples.x_value     <= f[0];
    samples.x_rate      <= f[1];
    samples.x_target    <= f[2];
    samples.y_value     <= f[3];
    samples.y_rate      <= f[4];
    samples.y_target    <= f[5];
    samples.turn_value  <= f[6];
    samples.turn_rate   <= f[7];
    samples.turn_target <= f[8];
    do @(posedge clk); while (!samples.ready);
    sets_sent++;
  endtask

  // wait for every expected command set to come back
  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_settings(input logic [locm_pkg::CfgDataW-1:0] vals [8]);
    for (int r = locm_pkg::CfgGainXPos; r <= locm_pkg::CfgOutputLimit; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= r[locm_pkg::CfgIdxW-1:0];
      cfg_data  <= vals[r];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [DW-1:0] pick_field();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return DW'($urandom_range(1535) - 768);
    if (sel < 8) return DW'($urandom());
    case ($urandom_range(4))
      0: return MaxV;
      1: return MinV;
      2: return '0;
      3: return DW'(-1);
      default: return 1;
    endcase
  endfunction

  function automatic logic [locm_pkg::CfgDataW-1:0] pick_gain();
    if ($urandom_range(2) == 0) return locm_pkg::CfgDataW'($urandom());
    return locm_pkg::CfgDataW'($urandom_range(4095) - 2048);
  endfunction

  initial begin
    logic [locm_pkg::CfgDataW-1:0] vals [8];
    logic signed [DW-1:0] axes [9];
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    samples.valid <= 1'b0;
    samples.x_value <= '0;
    samples.x_rate <= '0;
    samples.x_target <= '0;
    samples.y_value <= '0;
    samples.y_rate <= '0;
    samples.y_target <= '0;
    samples.turn_value <= '0;
    samples.turn_rate <= '0;
    samples.turn_target <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed sets under reset gains: field extremes, single axes, floor rounding
    send_axes('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_axes('{MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, MaxV});
    send_axes('{MinV, MinV, MinV, MinV, MinV, MinV, MinV, MinV, MinV});
    send_axes('{MaxV, 0, MinV, 0, 0, 0, 0, 0, 0});
    send_axes('{MinV, 0, MaxV, 0, 0, 0, 0, 0, 0});
    send_axes('{0, MaxV, 0, 0, MinV, 0, 0, MaxV, 0});
    send_axes('{0, MinV, 0, 0, MaxV, 0, 0, MinV, 0});
    send_axes('{0, 0, 0, MaxV, 0, MinV, 0, 0, 0});
    send_axes('{0, 0, 0, 0, 0, 0, MinV, 0, MaxV});
    send_axes('{1, 0, 0, 1, 0, 0, 1, 0, 0});
    send_axes('{-1, 0, 0, -1, 0, 0, -1, 0, 0});
    send_axes('{0, -1, 0, 0, -1, 0, 0, -1, 0});
    send_axes('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                16'sh5555, 16'shaaaa, 16'sh5555});
    send_axes('{0, 0, 0, 1000, 0, 0, 1000, 256, -256});
    samples.valid <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        drain();
        for (int r = locm_pkg::CfgGainXPos; r < locm_pkg::CfgWheelScale; r++)
          vals[r] = pick_gain();
        vals[locm_pkg::CfgWheelScale] = ($urandom_range(3) == 0) ?
            locm_pkg::CfgDataW'($urandom()) :
            locm_pkg::CfgDataW'($urandom_range(1023) - 512);
        vals[locm_pkg::CfgOutputLimit] = ($urandom_range(1) == 0) ?
            locm_pkg::CfgDataW'($urandom()) :
            locm_pkg::CfgDataW'($urandom_range(255));
        case (p * 2 + s)
          0: begin
            for (int r = locm_pkg::CfgGainXPos; r < locm_pkg::CfgWheelScale; r++)
              vals[r] = MaxV;
            vals[locm_pkg::CfgWheelScale] = MaxV;
            vals[locm_pkg::CfgOutputLimit] = 16'h7fff;
          end
          1: begin
            for (int r = locm_pkg::CfgGainXPos; r < locm_pkg::CfgWheelScale; r++)
              vals[r] = MinV;
            vals[locm_pkg::CfgWheelScale] = MinV;
            vals[locm_pkg::CfgOutputLimit] = 16'h7fff;
          end
          2: vals[locm_pkg::CfgOutputLimit] = '0;
          3: vals[locm_pkg::CfgWheelScale] = '0;
          4: begin
            // negative gains and scale, modest sizes so floor rounding shows
            for (int r = locm_pkg::CfgGainXPos; r < locm_pkg::CfgWheelScale; r++)
              vals[r] = locm_pkg::CfgDataW'(-$signed($urandom_range(1024, 1)));
            vals[locm_pkg::CfgWheelScale] = -16'sd256;
            vals[locm_pkg::CfgOutputLimit] = 16'd16384;
          end
          default: ;
        endcase
        write_settings(vals);
        src_idle = src_pct[p];
        snk_stall = snk_pct[p];
        // output held off while the sender keeps offering, so the pipeline backs up
        if (p == 0 && s == 1) hold_req = 1'b1;
        for (int i = 0; i < SetsPerSetting; i++) begin
          foreach (axes[j]) axes[j] = pick_field();
          send_axes(axes);
        end
        samples.valid <= 1'b0;
      end
    end

    drain();
    repeat (locm_pkg::Stages + 4) @(posedge clk);
    $display("Covered %0d sample sets under %0d register settings (reset, extremes, zero limit,",
             sets_sent, settings_used + 1);
    $display("zero and negative scale, random) across four idle/stall mixes and one long output hold.");
    if (failures == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off when requested
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    commands.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        commands.ready <= 1'b0;
        hold_left--;
      end else begin
        commands.ready <= ($urandom_range(99) >= snk_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (samples.valid && samples.ready) ||
        (commands.valid && commands.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
